// ----- src/rpf_pkg.sv -----
// Shared types, constants and the palette lookup for the RGB565 palette fade block.
// No dependencies; every other file of the block imports this package.
package rpf_pkg;

  localparam int unsigned ColorW   = 16;
  localparam int unsigned IndexW   = 3;
  localparam int unsigned StepW    = 8;
  localparam int unsigned ChanW    = 6;   // widest channel (green)
  localparam int unsigned ProdW    = ChanW + StepW;
  localparam int unsigned DivCycles = 3;  // two quotient bits per cycle, six bits total
  localparam int unsigned IterW    = 2;
  localparam logic [StepW-1:0] StepsReset = 8'd20;

  // Color channel being worked on by the shared divider
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load;  // item accepted: snapshot colors, step the fade state
    logic  mul;   // form |end - start| * step for the current channel
    logic  div;   // run two divider steps
    logic  last;  // final divider step: write back the channel result
    chan_e chan;
  } rpf_cmd_t;

  // Fixed rainbow palette, RGB565
  function automatic logic [ColorW-1:0] palette_color(input logic [IndexW-1:0] idx);
    logic [ColorW-1:0] c;
    unique case (idx)
      3'd0:    c = 16'hF800;
      3'd1:    c = 16'hFC00;
      3'd2:    c = 16'hFFE0;
      3'd3:    c = 16'h07E0;
      3'd4:    c = 16'h001F;
      3'd5:    c = 16'h781F;
      3'd6:    c = 16'hF81F;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

// ----- src/rpf_if.sv -----
// Valid/ready channel interfaces for fade ticks and fade results.
// Depends on rpf_pkg for field widths.
interface rpf_in_if import rpf_pkg::*; ();
  logic valid;
  logic ready;
  logic hold;

  modport source (output valid, output hold, input ready);
  modport sink   (input valid, input hold, output ready);
endinterface

interface rpf_out_if import rpf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ColorW-1:0] color;
  logic [IndexW-1:0] palette_position;
  logic [StepW-1:0]  fade_position;

  modport source (output valid, output color, output palette_position,
                  output fade_position, input ready);
  modport sink   (input valid, input color, input palette_position,
                  input fade_position, output ready);
endinterface

// ----- src/rpf_ctrl.sv -----
// Controller FSM for the palette fade: sequences multiply and divide steps per channel.
// Depends on rpf_pkg for the command struct and channel codes.
module rpf_ctrl import rpf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rpf_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  localparam logic [IterW-1:0] IterLast = IterW'(DivCycles - 1);

  state_e           state_q, state_d;
  chan_e            chan_q, chan_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             div_last;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign div_last    = (state_q == ST_DIV) && (iter_q == IterLast);

  // Drive datapath commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul  = (state_q == ST_MUL);
    cmd_o.div  = (state_q == ST_DIV);
    cmd_o.last = div_last;
    cmd_o.chan = chan_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    iter_d  = iter_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
          chan_d  = CH_RED;
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
        iter_d  = '0;
      end
      ST_DIV: begin
        if (div_last) begin
          unique case (chan_q)
            CH_RED: begin
              chan_d  = CH_GREEN;
              state_d = ST_MUL;
            end
            CH_GREEN: begin
              chan_d  = CH_BLUE;
              state_d = ST_MUL;
            end
            default: state_d = ST_OUT;
          endcase
        end else begin
          iter_d = iter_q + IterW'(1);
        end
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chan_q  <= CH_RED;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
      iter_q  <= iter_d;
    end
  end

  // Divider iteration never runs past its last step
  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (iter_q <= IterLast))
    else $error("divider iteration count out of range");

  // A finished result is held until the receiver takes it
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_ready_i) |=> (state_q == ST_OUT))
    else $error("result dropped before transfer");

  // Blue is the last channel: after it the result is presented
  a_blue_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_last && chan_q == CH_BLUE) |=> (state_q == ST_OUT))
    else $error("result not presented after blue channel");

endmodule

// ----- src/rpf_datapath.sv -----
// Datapath for the palette fade: fade state, step-count register, channel multiplier,
// shared two-bit-per-cycle restoring divider and result registers. Depends on rpf_pkg.
module rpf_datapath import rpf_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpf_cmd_t          cmd_i,
  input  logic              hold_i,
  input  logic              cfg_we_i,
  input  logic [StepW-1:0]  cfg_steps_i,
  output logic [ColorW-1:0] color_o,
  output logic [IndexW-1:0] palette_position_o,
  output logic [StepW-1:0]  fade_position_o
);

  localparam logic [IndexW:0] Entries = (IndexW+1)'(PALETTE_ENTRIES);

  // Fade state and configuration
  logic [StepW-1:0]  steps_q;
  logic [IndexW-1:0] pal_idx_q, pal_idx_d;
  logic [StepW-1:0]  step_q, step_d;

  // Per-item snapshot
  logic [ColorW-1:0] c0_q, c1_q;
  logic [StepW-1:0]  s_q;
  logic              bypass_q;
  logic [IndexW-1:0] pos_idx_q;

  // Channel arithmetic
  logic [ChanW-1:0]  a_q;
  logic              neg_q;
  logic [StepW-1:0]  rem_q, rem_d;
  logic [ChanW-1:0]  dvd_q, dvd_d;
  logic [ChanW-1:0]  quo_q, quo_d;
  logic [4:0]        res_r_q, res_b_q;
  logic [5:0]        res_g_q;

  logic [IndexW-1:0] idx_cur, idx_nxt;
  logic [IndexW:0]   idx_inc;
  logic [StepW-1:0]  step_inc;
  logic              wrap;
  logic [ChanW-1:0]  ch_a, ch_b, mag;
  logic signed [ChanW:0] diff;
  logic [ProdW-1:0]  prod;
  logic [ChanW-1:0]  res;

  // Current and next palette entry, next fade state
  always_comb begin
    idx_cur  = (pal_idx_q >= Entries[IndexW-1:0] && Entries[IndexW] == 1'b0) ? '0 : pal_idx_q;
    idx_inc  = {1'b0, idx_cur} + (IndexW+1)'(1);
    idx_nxt  = (idx_inc >= Entries) ? '0 : idx_inc[IndexW-1:0];
    step_inc = step_q + StepW'(1);
    wrap     = (step_inc >= steps_q);
    step_d   = wrap ? '0 : step_inc;
    pal_idx_d = wrap ? idx_nxt : idx_cur;
  end

  // Select the channel endpoints and form |end - start| * step
  always_comb begin
    unique case (cmd_i.chan)
      CH_RED: begin
        ch_a = {1'b0, c0_q[15:11]};
        ch_b = {1'b0, c1_q[15:11]};
      end
      CH_GREEN: begin
        ch_a = c0_q[10:5];
        ch_b = c1_q[10:5];
      end
      CH_BLUE: begin
        ch_a = {1'b0, c0_q[4:0]};
        ch_b = {1'b0, c1_q[4:0]};
      end
      default: begin
        ch_a = '0;
        ch_b = '0;
      end
    endcase
    diff = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
    mag  = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
    prod = {{StepW{1'b0}}, mag} * {{ChanW{1'b0}}, s_q};
  end

  // Two restoring divide steps per cycle
  always_comb begin
    logic [StepW:0] t;
    rem_d = rem_q;
    dvd_d = dvd_q;
    quo_d = quo_q;
    for (int k = 0; k < 2; k++) begin
      t     = {rem_d, dvd_d[ChanW-1]};
      dvd_d = {dvd_d[ChanW-2:0], 1'b0};
      if (t >= {1'b0, steps_q}) begin
        rem_d = StepW'(t - {1'b0, steps_q});
        quo_d = {quo_d[ChanW-2:0], 1'b1};
      end else begin
        rem_d = t[StepW-1:0];
        quo_d = {quo_d[ChanW-2:0], 1'b0};
      end
    end
    // Apply the sign of the difference, truncating toward zero
    res = a_q + (neg_q ? (ChanW'(0) - quo_d) : quo_d);
  end

  // Configuration and fade state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q   <= StepsReset;
      pal_idx_q <= '0;
      step_q    <= '0;
    end else begin
      if (cfg_we_i) steps_q <= cfg_steps_i;
      if (cmd_i.load && !hold_i) begin
        step_q    <= step_d;
        pal_idx_q <= pal_idx_d;
      end
    end
  end

  // Snapshot the item, run multiply and divide, write back channel results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c0_q      <= palette_color(idx_cur);
      c1_q      <= palette_color(idx_nxt);
      s_q       <= step_q;
      bypass_q  <= (step_q >= steps_q);
      pos_idx_q <= idx_cur;
    end
    if (cmd_i.mul) begin
      a_q   <= ch_a;
      neg_q <= diff[ChanW];
      rem_q <= prod[ProdW-1:ChanW];
      dvd_q <= prod[ChanW-1:0];
      quo_q <= '0;
    end
    if (cmd_i.div) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
      quo_q <= quo_d;
    end
    if (cmd_i.last) begin
      unique case (cmd_i.chan)
        CH_RED:   res_r_q <= res[4:0];
        CH_GREEN: res_g_q <= res;
        CH_BLUE:  res_b_q <= res[4:0];
        default:  ;
      endcase
    end
  end

  assign color_o            = bypass_q ? c1_q : {res_r_q, res_g_q, res_b_q};
  assign palette_position_o = pos_idx_q;
  assign fade_position_o    = s_q;

  // A held tick leaves the fade state untouched
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && hold_i && !cfg_we_i) |=> ($stable(pal_idx_q) && $stable(step_q)))
    else $error("fade state changed on a held tick");

  // Palette index stays within the palette
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pal_idx_q} < Entries))
    else $error("palette index out of range");

endmodule

// ----- src/rgb565_palette_fade_generator.sv -----
// Top level of the RGB565 palette fade generator: ties controller and datapath to the
// tick and result channels. Depends on rpf_pkg, rpf_if, rpf_ctrl and rpf_datapath.
//
// Usage:
//   in_i  (sink)   : one tick per transfer; hold=1 reports the color without advancing.
//   out_o (source) : one result per tick: RGB565 color, palette index and step used.
//   cfg_steps_we_i / cfg_steps_i : write the steps-per-fade register (reset 20).
//     Write only while no tick is in flight.
// Timing:
//   A tick is taken in the idle state and snapshotted at the transfer edge; the result
//   is valid once each channel has run through a multiply state and the divider states
//   of the shared two-bit-per-cycle divider. One tick is worked at a time, so a new tick
//   is taken the cycle after the result transfers.
// Reset:
//   Asynchronous, active low; fade starts at palette entry 0, step 0.
// Stall:
//   The result and its valid hold until the receiver takes it; no new tick is taken
//   meanwhile.
module rgb565_palette_fade_generator import rpf_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rpf_in_if.sink           in_i,
  rpf_out_if.source        out_o,
  input  logic             cfg_steps_we_i,
  input  logic [StepW-1:0] cfg_steps_i
);

  rpf_cmd_t cmd;

  // Sequence the per-channel work
  rpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Fade state and interpolation arithmetic
  rpf_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .hold_i             (in_i.hold),
    .cfg_we_i           (cfg_steps_we_i),
    .cfg_steps_i        (cfg_steps_i),
    .color_o            (out_o.color),
    .palette_position_o (out_o.palette_position),
    .fade_position_o    (out_o.fade_position)
  );

endmodule

// ----- dv/rpf_fade_checker.sv -----
// Result checker for the RGB565 palette fade generator: watches the tick, result and
// steps-per-fade ports, predicts each fade color and compares every result in order.
// Depends on rpf_pkg and the rpf_in_if / rpf_out_if interfaces.
module rpf_fade_checker import rpf_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rpf_in_if                in_mon_i,
  rpf_out_if               out_mon_i,
  input  logic             cfg_steps_we_i,
  input  logic [StepW-1:0] cfg_steps_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      results_seen_o
);

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic [IndexW-1:0] palette_position;
    logic [StepW-1:0]  fade_position;
  } fade_result_t;

  // Rainbow entries, entry 0 in the low bits
  localparam logic [7*ColorW-1:0] RainbowTable = {
    16'hF81F, 16'h781F, 16'h001F, 16'h07E0, 16'hFFE0, 16'hFC00, 16'hF800
  };
  localparam int unsigned ReportLimit = 10;

  logic [StepW-1:0]  steps_per_fade;
  logic [IndexW-1:0] fade_index;
  logic [StepW-1:0]  fade_step;
  fade_result_t      expected_fades[$];
  int unsigned       fails;
  int unsigned       results_seen;

  function automatic logic [IndexW-1:0] following_entry(input logic [IndexW-1:0] idx);
    return (int'(idx) + 1 >= int'(PALETTE_ENTRIES)) ? '0 : idx + 3'd1;
  endfunction

  function automatic logic [ColorW-1:0] rainbow(input logic [IndexW-1:0] idx);
    return RainbowTable[idx*ColorW +: ColorW];
  endfunction

  // Signed integer division truncates toward zero, as the channel math requires
  function automatic int lerp_channel(input int a, input int b, input int s, input int n);
    return a + ((b - a) * s) / n;
  endfunction

  function automatic logic [ColorW-1:0] fade_color(input logic [IndexW-1:0] idx,
                                                   input logic [StepW-1:0]  step,
                                                   input logic [StepW-1:0]  steps);
    logic [ColorW-1:0] c0;
    logic [ColorW-1:0] c1;
    int r;
    int g;
    int b;
    c0 = rainbow(idx);
    c1 = rainbow(following_entry(idx));
    // Step at or past the count lands exactly on the next entry
    if (step >= steps) return c1;
    r = lerp_channel(int'(c0[15:11]), int'(c1[15:11]), int'(step), int'(steps));
    g = lerp_channel(int'(c0[10:5]), int'(c1[10:5]), int'(step), int'(steps));
    b = lerp_channel(int'(c0[4:0]), int'(c1[4:0]), int'(step), int'(steps));
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    fade_result_t want;
    fade_result_t got;
    if (!rst_ni) begin
      steps_per_fade = StepsReset;
      fade_index     = '0;
      fade_step      = '0;
      expected_fades.delete();
      fails          = 0;
      results_seen   = 0;
    end else begin
      if (cfg_steps_we_i) steps_per_fade = cfg_steps_i;

      // Predict the result of an accepted tick, then advance the fade unless held
      if (in_mon_i.valid && in_mon_i.ready) begin
        want.color            = fade_color(fade_index, fade_step, steps_per_fade);
        want.palette_position = fade_index;
        want.fade_position    = fade_step;
        expected_fades.push_back(want);
        if (!in_mon_i.hold) begin
          fade_step = fade_step + 8'd1;
          if (fade_step >= steps_per_fade) begin
            fade_step  = '0;
            fade_index = following_entry(fade_index);
          end
        end
      end

      // Compare each result transfer with the oldest prediction
      if (out_mon_i.valid && out_mon_i.ready) begin
        results_seen++;
        got.color            = out_mon_i.color;
        got.palette_position = out_mon_i.palette_position;
        got.fade_position    = out_mon_i.fade_position;
        if (expected_fades.size() == 0) begin
          if (fails < ReportLimit)
            $display("%0t: unexpected result color=%h pos=%0d step=%0d", $realtime,
                     got.color, got.palette_position, got.fade_position);
          fails++;
        end else begin
          want = expected_fades.pop_front();
          if (got.color != want.color || got.palette_position != want.palette_position ||
              got.fade_position != want.fade_position) begin
            if (fails < ReportLimit)
              $display("%0t: mismatch color exp=%h got=%h pos exp=%0d got=%0d step exp=%0d got=%0d",
                       $realtime, want.color, got.color, want.palette_position,
                       got.palette_position, want.fade_position, got.fade_position);
            fails++;
          end
        end
      end
    end
    fail_count_o   <= fails;
    pending_o      <= expected_fades.size();
    results_seen_o <= results_seen;
  end

endmodule

// ----- dv/tb_rgb565_palette_fade_generator.sv -----
// Testbench top for the RGB565 palette fade generator: clock, reset, tick and
// steps-per-fade stimulus, random result stalls, watchdog and verdict.
// Depends on rpf_pkg, rpf_if, the block under test and rpf_fade_checker.
module tb_rgb565_palette_fade_generator;
  import rpf_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomTicks = 1600;
  localparam int unsigned DrainCycles = 20;

  logic             clk;
  logic             rst_n;
  logic             steps_we;
  logic [StepW-1:0] steps_data;
  logic             quiet;
  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      results_seen;
  int unsigned      ticks_sent;
  int unsigned      ticks_held;
  int unsigned      settings_used;
  int unsigned      idle_cycles;

  rpf_in_if  tick_if ();
  rpf_out_if fade_if ();

  rgb565_palette_fade_generator DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_i           (tick_if),
    .out_o          (fade_if),
    .cfg_steps_we_i (steps_we),
    .cfg_steps_i    (steps_data)
  );

  rpf_fade_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_mon_i       (tick_if),
    .out_mon_i      (fade_if),
    .cfg_steps_we_i (steps_we),
    .cfg_steps_i    (steps_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stall the result channel about a third of the time, except in quiet stretches
  always @(posedge clk) begin
    fade_if.ready <= quiet || ($urandom_range(0, 99) >= 33);
  end

  // Count cycles without any transfer and give up when the block stops moving
  always @(posedge clk) begin
    if (!rst_n || (tick_if.valid && tick_if.ready) || (fade_if.valid && fade_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb_rgb565_palette_fade_generator: done, errors");
        $finish;
      end
    end
  end

  // Offer one tick after random idle cycles and hold it until transfer
  task automatic send_tick(input logic h);
    while (!quiet && $urandom_range(0, 99) < 33) begin
      tick_if.valid <= 1'b0;
      @(posedge clk);
    end
    tick_if.valid <= 1'b1;
    tick_if.hold  <= h;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    ticks_sent++;
    if (h) ticks_held++;
  endtask

  // Drop valid and wait until every tick has produced its result
  task automatic drain_results();
    tick_if.valid <= 1'b0;
    @(posedge clk);
    while (results_seen < ticks_sent) @(posedge clk);
  endtask

  task automatic write_steps(input logic [StepW-1:0] value);
    drain_results();
    steps_we   <= 1'b1;
    steps_data <= value;
    @(posedge clk);
    steps_we   <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      count;
    logic [StepW-1:0] steps;
    tick_if.valid = 1'b0;
    tick_if.hold  = 1'b0;
    steps_we      = 1'b0;
    steps_data    = '0;
    quiet         = 1'b0;
    rst_n         = 1'b0;
    ticks_sent    = 0;
    ticks_held    = 0;
    settings_used = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset count: hold at step 0, advance, then hold mid-fade
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    send_tick(1'b1);
    // Lower the count below the current step: next entry, then wrap the step
    write_steps(8'd2);
    send_tick(1'b1);
    send_tick(1'b0);
    // Zero count: every advance moves one entry, all the way around the palette
    write_steps(8'd0);
    repeat (8) send_tick(1'b0);
    send_tick(1'b1);
    // Largest and smallest nonzero counts
    write_steps(8'd255);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    write_steps(8'd1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);

    // Random phases: long 255-step fade first so the step climbs to its top
    phase = 0;
    count = ticks_sent + RandomTicks;
    while (ticks_sent < count) begin
      case (phase)
        0:       steps = 8'd255;
        1:       steps = 8'd0;
        2:       steps = 8'd1;
        default: steps = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                     : 8'($urandom_range(2, 16));
      endcase
      write_steps(steps);
      quiet <= (phase == 3);
      repeat ((phase == 0) ? 400 : $urandom_range(40, 160))
        send_tick($urandom_range(0, 3) == 0);
      phase++;
    end
    quiet <= 1'b0;

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d ticks (%0d held) across %0d steps-per-fade settings;",
             ticks_sent, ticks_held, settings_used);
    $display("compared %0d fade results in order.", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_rgb565_palette_fade_generator: done, clean");
    end else begin
      $display("tb_rgb565_palette_fade_generator: done, errors");
    end
    $finish;
  end

endmodule
